/* rtl/gas_sensor_ppm_estimator_top_defines.svh */
// Assertion macros for the gas sensor ppm estimator.
// Used by the top level; expects clk and rst_n in scope.
`ifndef GAS_SENSOR_PPM_ESTIMATOR_TOP_DEFINES_SVH
`define GAS_SENSOR_PPM_ESTIMATOR_TOP_DEFINES_SVH

// same-cycle implication
`define GSPE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gspe check failed");

// next-cycle implication
`define GSPE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gspe check failed");

`endif

/* rtl/gspe_pkg.sv */
// Shared types, constants and tables for the gas sensor ppm estimator.
// No dependencies.
package gspe_pkg;

    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 24;
    localparam int DIV_CNT_W = 6;

    localparam logic [23:0] MAX24     = 24'hFFFFFF;
    localparam logic [12:0] SUPPLY_MV = 13'd5000;
    localparam logic [15:0] LN2_Q16   = 16'd45426;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [30:0] ONE_Q30   = 31'h40000000;

    localparam logic [2:0] CFG_LOAD_RES  = 3'd0;
    localparam logic [2:0] CFG_CLEAN_AIR = 3'd1;
    localparam logic [2:0] CFG_REF_RO    = 3'd2;
    localparam logic [2:0] CFG_CURVE_A   = 3'd3;
    localparam logic [2:0] CFG_CURVE_B   = 3'd4;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_ZERO_V     = 2'd1;
    localparam logic [1:0] STAT_ZERO_RO    = 2'd2;
    localparam logic [1:0] STAT_ZERO_SLOPE = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SMUL,
        ST_SDIV_GO,
        ST_SDIV_WAIT,
        ST_ACC,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_CAL_GO,
        ST_CAL_WAIT,
        ST_RATIO_GO,
        ST_RATIO_WAIT,
        ST_LNORM,
        ST_LSQ,
        ST_LADJ,
        ST_LNMUL,
        ST_YSETUP,
        ST_YDIV_GO,
        ST_YDIV_WAIT,
        ST_EMUL,
        ST_EXPSET,
        ST_EXPMUL,
        ST_EXPSHR,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

    function automatic logic [23:0] sat24(input logic [DIV_NUM_W-1:0] x);
        sat24 = (|x[DIV_NUM_W-1:24]) ? MAX24 : x[23:0];
    endfunction

    // 2^(2^-(k+1)) in Q.30
    function automatic logic [30:0] exp2_tab(input logic [3:0] k);
        unique case (k)
            4'd0:    exp2_tab = 31'd1518500250;
            4'd1:    exp2_tab = 31'd1276901417;
            4'd2:    exp2_tab = 31'd1170923762;
            4'd3:    exp2_tab = 31'd1121280436;
            4'd4:    exp2_tab = 31'd1097253708;
            4'd5:    exp2_tab = 31'd1085434109;
            4'd6:    exp2_tab = 31'd1079572136;
            4'd7:    exp2_tab = 31'd1076653033;
            4'd8:    exp2_tab = 31'd1075196444;
            4'd9:    exp2_tab = 31'd1074468888;
            4'd10:   exp2_tab = 31'd1074105294;
            4'd11:   exp2_tab = 31'd1073923544;
            4'd12:   exp2_tab = 31'd1073832680;
            4'd13:   exp2_tab = 31'd1073787251;
            4'd14:   exp2_tab = 31'd1073764537;
            default: exp2_tab = 31'd1073753181;
        endcase
    endfunction

endpackage

/* rtl/gspe_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on gspe_pkg for the request/response structs.
module gspe_div (
    input  logic                clk,
    input  logic                rst_n,
    input  gspe_pkg::div_req_t  req,
    output gspe_pkg::div_rsp_t  rsp
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [gspe_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [gspe_pkg::DIV_NUM_W-1:0] q_reg, q_next;
    logic [gspe_pkg::DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [gspe_pkg::DIV_DEN_W-1:0] den_reg, den_next;
    logic [gspe_pkg::DIV_DEN_W:0]   rem_sh;
    logic                           ge;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        rem_sh    = {rem_reg, q_reg[gspe_pkg::DIV_NUM_W-1]};
        ge        = (rem_sh >= {1'b0, den_reg});
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = req.num;
            rem_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? gspe_pkg::DIV_DEN_W'(rem_sh - {1'b0, den_reg})
                          : rem_sh[gspe_pkg::DIV_DEN_W-1:0];
            q_next   = {q_reg[gspe_pkg::DIV_NUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == gspe_pkg::DIV_CNT_W'(gspe_pkg::DIV_NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = q_reg;

endmodule

/* rtl/gas_sensor_ppm_estimator_top.sv */
// Top level of the gas sensor ppm estimator: sequencer, log/exp datapath, ports.
// Depends on gspe_pkg, gspe_div and gas_sensor_ppm_estimator_top_defines.svh.
//
// One sample is taken per transaction while the block is idle. A sample at zero
// volts or at/above supply skips the divider; any other sample goes through the
// 40-step shared serial divider. The last sample of a run adds the mean divide,
// then either the Ro divide for calibration, or the ratio divide, a leading-one
// search, 16 squaring steps, the slope divide, 16 exponent steps and an output
// shift of up to 40 places.
// A finished result sits in the output register while the next run proceeds.
`include "gas_sensor_ppm_estimator_top_defines.svh"

module gas_sensor_ppm_estimator_top #(
    parameter int SAMPLE_COUNT = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // [12:0] sample_mv
    input  logic         s_axis_tuser,   // [0] cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [23:0] mean_resistance, [47:24] ratio, [71:48] ppm, [95:72] new_ro, [97:96] status
    output logic [103:0] m_axis_tdata,
    output logic         m_axis_tuser    // [0] result_kind
);

    localparam int CNT_W = $clog2(SAMPLE_COUNT + 1);

    gspe_pkg::state_t state_reg, state_next;
    gspe_pkg::div_req_t div_req;
    gspe_pkg::div_rsp_t div_rsp;

    logic [19:0]        rl_reg, rl_next;
    logic [15:0]        car_reg, car_next;
    logic [15:0]        a_reg, a_next;
    logic [15:0]        b_reg, b_next;
    logic [23:0]        ro_reg, ro_next;
    logic [29:0]        sum_reg, sum_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               zv_reg, zv_next;
    logic               out_valid_reg, out_valid_next;

    logic               cmd_reg, cmd_next;
    logic [12:0]        v_reg, v_next;
    logic [32:0]        prod_reg, prod_next;
    logic [23:0]        r_reg, r_next;
    logic [23:0]        mean_reg, mean_next;
    logic [23:0]        ratio_reg, ratio_next;
    logic [23:0]        ppm_reg, ppm_next;
    logic [1:0]         status_reg, status_next;
    logic [23:0]        norm_reg, norm_next;
    logic [4:0]         p_reg, p_next;
    logic [30:0]        m_reg, m_next;
    logic [31:0]        sq_reg, sq_next;
    logic [15:0]        frac_reg, frac_next;
    logic [3:0]         k_reg, k_next;
    logic [36:0]        lnp_reg, lnp_next;
    logic               lneg_reg, lneg_next;
    logic [22:0]        num_reg, num_next;
    logic               yneg_reg, yneg_next;
    logic [21:0]        ymag_reg, ymag_next;
    logic [22:0]        e_reg, e_next;
    logic [15:0]        f_reg, f_next;
    logic [5:0]         n_reg, n_next;
    logic [30:0]        acc_reg, acc_next;

    logic               okind_reg, okind_next;
    logic [23:0]        omean_reg, omean_next;
    logic [23:0]        oratio_reg, oratio_next;
    logic [23:0]        oppm_reg, oppm_next;
    logic [23:0]        oro_reg, oro_next;
    logic [1:0]         ostat_reg, ostat_next;

    gspe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        logic [12:0] smv;
        logic [23:0] q24;
        logic [21:0] lint;
        logic [20:0] lmag;
        logic [22:0] lnr;
        logic [21:0] nmag;
        logic [15:0] amag;
        logic [38:0] ep;
        logic [21:0] emag;
        logic [6:0]  ip;
        logic [7:0]  n8;
        logic [61:0] mp;

        smv  = s_axis_tdata[12:0];
        q24  = gspe_pkg::sat24(div_rsp.quo);
        lint = {6'(p_reg) - 6'd16, frac_reg};
        lmag = lint[21] ? 21'(-lint) : lint[20:0];
        lnr  = lneg_reg ? -23'(lnp_reg[36:16]) : 23'(lnp_reg[36:16]);
        nmag = num_reg[22] ? 22'(-num_reg) : num_reg[21:0];
        amag = a_reg[15] ? 16'(-a_reg) : a_reg;
        ep   = 39'(ymag_reg) * 39'(gspe_pkg::LOG2E_Q16);
        emag = ep[37:16];
        ip   = e_reg[22:16];
        n8   = 8'd22 - {ip[6], ip};
        mp   = '0;

        state_next     = state_reg;
        rl_next        = rl_reg;
        car_next       = car_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        ro_next        = ro_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        zv_next        = zv_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        v_next         = v_reg;
        prod_next      = prod_reg;
        r_next         = r_reg;
        mean_next      = mean_reg;
        ratio_next     = ratio_reg;
        ppm_next       = ppm_reg;
        status_next    = status_reg;
        norm_next      = norm_reg;
        p_next         = p_reg;
        m_next         = m_reg;
        sq_next        = sq_reg;
        frac_next      = frac_reg;
        k_next         = k_reg;
        lnp_next       = lnp_reg;
        lneg_next      = lneg_reg;
        num_next       = num_reg;
        yneg_next      = yneg_reg;
        ymag_next      = ymag_reg;
        e_next         = e_reg;
        f_next         = f_reg;
        n_next         = n_reg;
        acc_next       = acc_reg;
        okind_next     = okind_reg;
        omean_next     = omean_reg;
        oratio_next    = oratio_reg;
        oppm_next      = oppm_reg;
        oro_next       = oro_reg;
        ostat_next     = ostat_reg;
        div_req        = '0;
        s_axis_tready  = 1'b0;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            gspe_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd_next = s_axis_tuser;
                    v_next   = smv;
                    priority if (smv == 13'd0)
                    begin
                        r_next     = gspe_pkg::MAX24;
                        zv_next    = 1'b1;
                        state_next = gspe_pkg::ST_ACC;
                    end
                    else if (smv >= gspe_pkg::SUPPLY_MV)
                    begin
                        r_next     = '0;
                        state_next = gspe_pkg::ST_ACC;
                    end
                    else
                        state_next = gspe_pkg::ST_SMUL;
                end
            end
            gspe_pkg::ST_SMUL:
            begin
                prod_next  = 33'(gspe_pkg::SUPPLY_MV - v_reg) * 33'(rl_reg);
                state_next = gspe_pkg::ST_SDIV_GO;
            end
            gspe_pkg::ST_SDIV_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = 40'(prod_reg);
                div_req.den   = 24'(v_reg);
                state_next    = gspe_pkg::ST_SDIV_WAIT;
            end
            gspe_pkg::ST_SDIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    r_next     = q24;
                    state_next = gspe_pkg::ST_ACC;
                end
            end
            gspe_pkg::ST_ACC:
            begin
                sum_next = sum_reg + 30'(r_reg);
                if (cnt_reg == CNT_W'(SAMPLE_COUNT - 1))
                begin
                    cnt_next   = '0;
                    state_next = gspe_pkg::ST_MEAN_GO;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = gspe_pkg::ST_IDLE;
                end
            end
            gspe_pkg::ST_MEAN_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = 40'(sum_reg);
                div_req.den   = 24'(SAMPLE_COUNT);
                state_next    = gspe_pkg::ST_MEAN_WAIT;
            end
            gspe_pkg::ST_MEAN_WAIT:
            begin
                if (div_rsp.done)
                begin
                    mean_next   = q24;
                    sum_next    = '0;
                    zv_next     = 1'b0;
                    ratio_next  = '0;
                    ppm_next    = '0;
                    status_next = gspe_pkg::STAT_OK;
                    if (cmd_reg)
                    begin
                        priority if (zv_reg)
                        begin
                            status_next = gspe_pkg::STAT_ZERO_V;
                            state_next  = gspe_pkg::ST_OUT;
                        end
                        else if (car_reg == 16'd0)
                        begin
                            ro_next    = gspe_pkg::MAX24;
                            state_next = gspe_pkg::ST_OUT;
                        end
                        else
                            state_next = gspe_pkg::ST_CAL_GO;
                    end
                    else
                    begin
                        priority if (zv_reg)
                        begin
                            status_next = gspe_pkg::STAT_ZERO_V;
                            ratio_next  = gspe_pkg::MAX24;
                            ppm_next    = gspe_pkg::MAX24;
                            state_next  = gspe_pkg::ST_OUT;
                        end
                        else if (ro_reg == 24'd0)
                        begin
                            status_next = gspe_pkg::STAT_ZERO_RO;
                            ratio_next  = gspe_pkg::MAX24;
                            ppm_next    = gspe_pkg::MAX24;
                            state_next  = gspe_pkg::ST_OUT;
                        end
                        else
                            state_next = gspe_pkg::ST_RATIO_GO;
                    end
                end
            end
            gspe_pkg::ST_CAL_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = {8'd0, mean_reg, 8'd0};
                div_req.den   = 24'(car_reg);
                state_next    = gspe_pkg::ST_CAL_WAIT;
            end
            gspe_pkg::ST_CAL_WAIT:
            begin
                if (div_rsp.done)
                begin
                    ro_next    = q24;
                    state_next = gspe_pkg::ST_OUT;
                end
            end
            gspe_pkg::ST_RATIO_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = {mean_reg, 16'd0};
                div_req.den   = ro_reg;
                state_next    = gspe_pkg::ST_RATIO_WAIT;
            end
            gspe_pkg::ST_RATIO_WAIT:
            begin
                if (div_rsp.done)
                begin
                    ratio_next = q24;
                    priority if (a_reg == 16'd0)
                    begin
                        status_next = gspe_pkg::STAT_ZERO_SLOPE;
                        ppm_next    = gspe_pkg::MAX24;
                        state_next  = gspe_pkg::ST_OUT;
                    end
                    else if (q24 == 24'd0)
                    begin
                        ppm_next   = a_reg[15] ? gspe_pkg::MAX24 : 24'd0;
                        state_next = gspe_pkg::ST_OUT;
                    end
                    else
                    begin
                        norm_next  = q24;
                        p_next     = 5'd23;
                        state_next = gspe_pkg::ST_LNORM;
                    end
                end
            end
            gspe_pkg::ST_LNORM:
            begin
                // leading-one search, one position per cycle
                if (p_reg != 5'd0 && !norm_reg[23])
                begin
                    norm_next = {norm_reg[22:0], 1'b0};
                    p_next    = p_reg - 1'b1;
                end
                else
                begin
                    m_next     = {norm_reg, 7'd0};
                    frac_next  = '0;
                    k_next     = '0;
                    state_next = gspe_pkg::ST_LSQ;
                end
            end
            gspe_pkg::ST_LSQ:
            begin
                mp         = 62'(m_reg) * 62'(m_reg);
                sq_next    = mp[61:30];
                state_next = gspe_pkg::ST_LADJ;
            end
            gspe_pkg::ST_LADJ:
            begin
                frac_next = {frac_reg[14:0], sq_reg[31]};
                m_next    = sq_reg[31] ? sq_reg[31:1] : sq_reg[30:0];
                k_next    = k_reg + 1'b1;
                if (k_reg == 4'd15)
                    state_next = gspe_pkg::ST_LNMUL;
                else
                    state_next = gspe_pkg::ST_LSQ;
            end
            gspe_pkg::ST_LNMUL:
            begin
                lnp_next   = 37'(lmag) * 37'(gspe_pkg::LN2_Q16);
                lneg_next  = lint[21];
                state_next = gspe_pkg::ST_YSETUP;
            end
            gspe_pkg::ST_YSETUP:
            begin
                num_next   = lnr - {{3{b_reg[15]}}, b_reg, 4'd0};
                state_next = gspe_pkg::ST_YDIV_GO;
            end
            gspe_pkg::ST_YDIV_GO:
            begin
                // magnitudes through the divider, sign restored after: truncates toward zero
                yneg_next     = num_reg[22] ^ a_reg[15];
                div_req.start = 1'b1;
                div_req.num   = 40'({nmag, 12'd0});
                div_req.den   = 24'(amag);
                state_next    = gspe_pkg::ST_YDIV_WAIT;
            end
            gspe_pkg::ST_YDIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    // beyond 2^21 the exponent saturates either way
                    ymag_next  = (|div_rsp.quo[39:21]) ? 22'h200000 : {1'b0, div_rsp.quo[20:0]};
                    state_next = gspe_pkg::ST_EMUL;
                end
            end
            gspe_pkg::ST_EMUL:
            begin
                e_next     = yneg_reg ? -23'(emag) : 23'(emag);
                state_next = gspe_pkg::ST_EXPSET;
            end
            gspe_pkg::ST_EXPSET:
            begin
                priority if (!ip[6] && (ip[5:4] != 2'd0))
                begin
                    ppm_next   = gspe_pkg::MAX24;
                    state_next = gspe_pkg::ST_OUT;
                end
                else if (n8 > 8'd40)
                begin
                    ppm_next   = '0;
                    state_next = gspe_pkg::ST_OUT;
                end
                else
                begin
                    n_next     = n8[5:0];
                    acc_next   = gspe_pkg::ONE_Q30;
                    f_next     = e_reg[15:0];
                    k_next     = '0;
                    state_next = gspe_pkg::ST_EXPMUL;
                end
            end
            gspe_pkg::ST_EXPMUL:
            begin
                if (f_reg[15])
                begin
                    mp       = 62'(acc_reg) * 62'(gspe_pkg::exp2_tab(k_reg));
                    acc_next = mp[60:30];
                end
                f_next = {f_reg[14:0], 1'b0};
                k_next = k_reg + 1'b1;
                if (k_reg == 4'd15)
                    state_next = gspe_pkg::ST_EXPSHR;
            end
            gspe_pkg::ST_EXPSHR:
            begin
                if (n_reg != 6'd0)
                begin
                    acc_next = {1'b0, acc_reg[30:1]};
                    n_next   = n_reg - 1'b1;
                end
                else
                begin
                    ppm_next   = (|acc_reg[30:24]) ? gspe_pkg::MAX24 : acc_reg[23:0];
                    state_next = gspe_pkg::ST_OUT;
                end
            end
            gspe_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    okind_next     = cmd_reg;
                    omean_next     = mean_reg;
                    oratio_next    = ratio_reg;
                    oppm_next      = ppm_reg;
                    oro_next       = ro_reg;
                    ostat_next     = status_reg;
                    out_valid_next = 1'b1;
                    state_next     = gspe_pkg::ST_IDLE;
                end
            end
            default:
                state_next = gspe_pkg::ST_IDLE;
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                gspe_pkg::CFG_LOAD_RES:  rl_next  = cfg_data[19:0];
                gspe_pkg::CFG_CLEAN_AIR: car_next = cfg_data[15:0];
                gspe_pkg::CFG_REF_RO:    ro_next  = cfg_data;
                gspe_pkg::CFG_CURVE_A:   a_next   = cfg_data[15:0];
                gspe_pkg::CFG_CURVE_B:   b_next   = cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gspe_pkg::ST_IDLE;
            rl_reg        <= 20'd10000;
            car_reg       <= 16'd2516;
            a_reg         <= 16'hF88D;
            b_reg         <= 16'd5325;
            ro_reg        <= 24'd10000;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            zv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rl_reg        <= rl_next;
            car_reg       <= car_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            ro_reg        <= ro_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            zv_reg        <= zv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        v_reg      <= v_next;
        prod_reg   <= prod_next;
        r_reg      <= r_next;
        mean_reg   <= mean_next;
        ratio_reg  <= ratio_next;
        ppm_reg    <= ppm_next;
        status_reg <= status_next;
        norm_reg   <= norm_next;
        p_reg      <= p_next;
        m_reg      <= m_next;
        sq_reg     <= sq_next;
        frac_reg   <= frac_next;
        k_reg      <= k_next;
        lnp_reg    <= lnp_next;
        lneg_reg   <= lneg_next;
        num_reg    <= num_next;
        yneg_reg   <= yneg_next;
        ymag_reg   <= ymag_next;
        e_reg      <= e_next;
        f_reg      <= f_next;
        n_reg      <= n_next;
        acc_reg    <= acc_next;
        okind_reg  <= okind_next;
        omean_reg  <= omean_next;
        oratio_reg <= oratio_next;
        oppm_reg   <= oppm_next;
        oro_reg    <= oro_next;
        ostat_reg  <= ostat_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = okind_reg;
    assign m_axis_tdata  = {6'd0, ostat_reg, oro_reg, oppm_reg, oratio_reg, omean_reg};

    `GSPE_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy)
    `GSPE_ASSERT_IMP(a_cnt_in_range, 1'b1, cnt_reg <= CNT_W'(SAMPLE_COUNT - 1))
    `GSPE_ASSERT_NXT(a_out_no_overwrite,
        state_reg == gspe_pkg::ST_OUT && out_valid_reg && !m_axis_tready,
        state_reg == gspe_pkg::ST_OUT)
    `GSPE_ASSERT_IMP(a_cal_status,
        m_axis_tvalid && m_axis_tuser,
        ostat_reg == gspe_pkg::STAT_OK || ostat_reg == gspe_pkg::STAT_ZERO_V)

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for gas_sensor_ppm_estimator_top: sample runs in, results out.
// Depends on gspe_pkg and the RTL; a built-in predictor checks every result.
module tb;

    localparam int RUN_LEN = 8;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic        kind;
        logic [23:0] mean_r;
        logic [23:0] ratio;
        logic [23:0] ppm;
        logic [23:0] ro;
        logic [1:0]  status;
    } result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = gspe_pkg::CFG_LOAD_RES;
    logic [23:0]  cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata = '0;   // [12:0] sample_mv
    logic         s_axis_tuser = 1'b0; // [0] cmd
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [23:0] mean, [47:24] ratio, [71:48] ppm, [95:72] new_ro, [97:96] status
    logic [103:0] m_axis_tdata;
    logic         m_axis_tuser;        // [0] result_kind

    gas_sensor_ppm_estimator_top #(.SAMPLE_COUNT(RUN_LEN)) dut (.*);

    always #10 clk = ~clk;

    // predictor state
    logic [19:0] p_load = 20'd10000;
    logic [15:0] p_clean = 16'd2516;
    logic [23:0] p_ro = 24'd10000;
    logic signed [15:0] p_a = -16'sd1907;
    logic signed [15:0] p_b = 16'sd5325;
    logic [29:0] r_sum = '0;
    int          r_cnt = 0;
    logic        r_zero_v = 1'b0;

    result_t expected_results[$];
    int  n_err = 0;
    int  src_idle_pct = 0, snk_idle_pct = 0;
    bit  hold_sink = 0;
    longint cyc = 0;

    localparam longint EXP2_K[16] = '{
        1518500250, 1276901417, 1170923762, 1121280436,
        1097253708, 1085434109, 1079572136, 1076653033,
        1075196444, 1074468888, 1074105294, 1073923544,
        1073832680, 1073787251, 1073764537, 1073753181};

    function automatic longint log2_fix(longint r);
        int p;
        longint m, fr;
        p = 23;
        fr = 0;
        while (p > 0 && r[p] == 1'b0) p--;
        m = r << (30 - p);
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >>> 30;
            fr = fr << 1;
            if (m >= (64'sd1 << 31)) begin
                fr = fr | 1;
                m = m >>> 1;
            end
        end
        return longint'(p - 16) * 65536 + fr;
    endfunction

    function automatic longint exp2_fix(longint e);
        longint ip, f, n, acc;
        acc = 64'sd1 << 30;
        if (e >= 0) ip = e / 65536;
        else ip = -((-e + 65535) / 65536);
        f = e - ip * 65536;
        if (ip >= 16) return longint'(gspe_pkg::MAX24);
        for (int k = 0; k < 16; k++)
            if (f[15-k]) acc = (acc * EXP2_K[k]) >>> 30;
        n = 22 - ip;
        if (n > 40) return 0;
        acc = acc >>> n;
        return acc > longint'(gspe_pkg::MAX24) ? longint'(gspe_pkg::MAX24) : acc;
    endfunction

    function automatic longint gas_ppm(longint rt, longint a, longint b);
        longint lnr, y, e;
        if (rt == 0) return a < 0 ? longint'(gspe_pkg::MAX24) : 0;
        lnr = log2_fix(rt) * 45426 / 65536;
        y = (lnr - b * 16) * 4096 / a;
        e = y * 94548 / 65536;
        return exp2_fix(e);
    endfunction

    task automatic predict_sample(input logic cmd, input logic [12:0] mv);
        longint r, mean, rt, ppm, ro;
        result_t res;
        if (mv == 0) begin
            r = longint'(gspe_pkg::MAX24);
            r_zero_v = 1'b1;
        end else if (mv >= gspe_pkg::SUPPLY_MV) r = 0;
        else begin
            r = (longint'(5000 - mv) * p_load) / mv;
            if (r > longint'(gspe_pkg::MAX24)) r = longint'(gspe_pkg::MAX24);
        end
        r_sum = r_sum + r[29:0];
        r_cnt++;
        if (r_cnt < RUN_LEN) return;
        mean = r_sum / RUN_LEN;
        if (mean > longint'(gspe_pkg::MAX24)) mean = longint'(gspe_pkg::MAX24);
        res = '0;
        res.kind = cmd;
        res.mean_r = mean[23:0];
        if (cmd) begin
            if (r_zero_v) res.status = gspe_pkg::STAT_ZERO_V;
            else begin
                ro = (p_clean != 0) ? (mean * 256) / p_clean : longint'(gspe_pkg::MAX24);
                p_ro = ro > longint'(gspe_pkg::MAX24) ? gspe_pkg::MAX24 : ro[23:0];
            end
        end else if (r_zero_v) begin
            res.status = gspe_pkg::STAT_ZERO_V;
            res.ratio = gspe_pkg::MAX24;
            res.ppm = gspe_pkg::MAX24;
        end else if (p_ro == 0) begin
            res.status = gspe_pkg::STAT_ZERO_RO;
            res.ratio = gspe_pkg::MAX24;
            res.ppm = gspe_pkg::MAX24;
        end else begin
            rt = (mean << 16) / p_ro;
            if (rt > longint'(gspe_pkg::MAX24)) rt = longint'(gspe_pkg::MAX24);
            res.ratio = rt[23:0];
            if (p_a == 0) begin
                res.status = gspe_pkg::STAT_ZERO_SLOPE;
                res.ppm = gspe_pkg::MAX24;
            end else begin
                ppm = gas_ppm(rt, longint'(p_a), longint'(p_b));
                res.ppm = ppm[23:0];
            end
        end
        res.ro = p_ro;
        expected_results.push_back(res);
        r_sum = '0;
        r_cnt = 0;
        r_zero_v = 1'b0;
    endtask

    // one write, then write enable held low so back-to-back writes never collide
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            gspe_pkg::CFG_LOAD_RES:  p_load = val[19:0];
            gspe_pkg::CFG_CLEAN_AIR: p_clean = val[15:0];
            gspe_pkg::CFG_REF_RO:    p_ro = val;
            gspe_pkg::CFG_CURVE_A:   p_a = val[15:0];
            default:                 p_b = val[15:0];
        endcase
        @(posedge clk);
    endtask

    // valid stays up after a transaction; it drops only on an idle cycle or in drain
    task automatic send_sample(input logic cmd, input logic [12:0] mv);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {3'b000, mv};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_sample(cmd, mv);
    endtask

    // wait for every result, then let a finished run settle before a register write
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic logic [12:0] rand_mv();
        case ($urandom_range(9))
            0:       return 13'd0;
            1:       return 13'($urandom_range(8191, 5000));
            2:       return 13'($urandom_range(20, 1));
            default: return 13'($urandom_range(4999, 1));
        endcase
    endfunction

    // directed rows: cmd, mv
    typedef struct { logic cmd; logic [12:0] mv; } row_t;
    row_t dir_rows[24];

    // output side: ready with random idling plus an optional long hold-off
    always @(posedge clk)
    begin
        if (!rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= !hold_sink && ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        result_t got, exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata[23:0], m_axis_tdata[47:24],
                   m_axis_tdata[71:48], m_axis_tdata[95:72], m_axis_tdata[97:96]};
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction");
                n_err++;
            end else begin
                exp_r = expected_results.pop_front();
                if (got.kind !== exp_r.kind) begin
                    $error("result_kind exp %0d got %0d", exp_r.kind, got.kind); n_err++;
                end
                if (got.mean_r !== exp_r.mean_r) begin
                    $error("mean_resistance exp %0d got %0d", exp_r.mean_r, got.mean_r);
                    n_err++;
                end
                if (got.ratio !== exp_r.ratio) begin
                    $error("ratio exp %0d got %0d", exp_r.ratio, got.ratio); n_err++;
                end
                if (got.ppm !== exp_r.ppm) begin
                    $error("ppm exp %0d got %0d", exp_r.ppm, got.ppm); n_err++;
                end
                if (got.ro !== exp_r.ro) begin
                    $error("new_ro exp %0d got %0d", exp_r.ro, got.ro); n_err++;
                end
                if (got.status !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, got.status); n_err++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cyc++;
        if (cyc > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // long receiver hold-off while samples keep flowing
    initial
    begin
        wait (rst_n);
        repeat (40000) @(posedge clk);
        hold_sink = 1;
        repeat (3000) @(posedge clk);
        hold_sink = 0;
    end

    task automatic run_random(input int runs);
        logic cmd;
        int len;
        for (int i = 0; i < runs; i++) begin
            cmd = ($urandom_range(3) == 0);
            len = ($urandom_range(19) == 0) ? $urandom_range(RUN_LEN - 1, 1) : RUN_LEN;
            for (int j = 0; j < len; j++) begin
                // occasional mixed commands inside a run
                if ($urandom_range(15) == 0) send_sample(~cmd, rand_mv());
                else send_sample(cmd, rand_mv());
            end
        end
    endtask

    initial
    begin
        // directed: all-supply run, all-zero-voltage run, calibrate, extremes
        for (int i = 0; i < 24; i++) begin
            dir_rows[i].cmd = (i >= 16);
            dir_rows[i].mv = (i < 8) ? 13'd5000 : (i < 16) ? 13'd0 : 13'd2500;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 12; snk_idle_pct = 65;
        foreach (dir_rows[i]) send_sample(dir_rows[i].cmd, dir_rows[i].mv);
        drain();
        // supply-level run gives mean 0 and ratio 0: ppm is 0 with positive slope
        write_reg(gspe_pkg::CFG_CURVE_A, 24'h007FFF);
        for (int i = 0; i < RUN_LEN; i++) send_sample(1'b0, 13'h1FFF);
        drain();
        write_reg(gspe_pkg::CFG_CURVE_A, 24'h000000);
        write_reg(gspe_pkg::CFG_REF_RO, 24'd0);
        for (int i = 0; i < RUN_LEN; i++) send_sample(1'b0, 13'd1);
        drain();
        write_reg(gspe_pkg::CFG_CLEAN_AIR, 24'd0);
        for (int i = 0; i < RUN_LEN; i++) send_sample(1'b1, 13'd1);
        for (int i = 0; i < RUN_LEN; i++) send_sample(1'b0, 13'd4999);
        drain();

        // random phases over several register settings
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 3) begin src_idle_pct = 65; snk_idle_pct = 12; end
            if (ph == 6) begin src_idle_pct = 0; snk_idle_pct = 0; end
            write_reg(gspe_pkg::CFG_LOAD_RES, (ph == 0) ? 24'd1 : (ph == 1) ? 24'hFFFFF :
                      24'($urandom_range(1000000, 1)));
            write_reg(gspe_pkg::CFG_CLEAN_AIR, (ph == 2) ? 24'hFFFF : (ph == 3) ? 24'd1 :
                      24'($urandom_range(65535, 1)));
            write_reg(gspe_pkg::CFG_REF_RO, (ph == 4) ? 24'hFFFFFF :
                      24'($urandom_range(200000, 1)));
            write_reg(gspe_pkg::CFG_CURVE_A, (ph == 5) ? 24'h8000 : (ph == 6) ? 24'h7FFF :
                      24'($urandom_range(65535)));
            write_reg(gspe_pkg::CFG_CURVE_B, (ph == 5) ? 24'h7FFF : (ph == 6) ? 24'h8000 :
                      24'($urandom_range(65535)));
            run_random(30);
            drain();
        end

        if (n_err == 0 && expected_results.size() == 0)
            $display("tb: clean");
        else
        begin
            if (expected_results.size() != 0)
                $error("%0d results never arrived", expected_results.size());
            $display("tb: errors");
        end
        $finish;
    end
endmodule

/* gas_sensor_ppm_estimator_top.f */
+incdir+rtl
rtl/gspe_pkg.sv
rtl/gspe_div.sv
rtl/gas_sensor_ppm_estimator_top.sv
tb/sv/tb.sv
